/* rtl/spi_flash_command_sequencer_top_assert.svh */
// Assertion macros for the flash sequencer checker.
`ifndef SPI_FLASH_COMMAND_SEQUENCER_TOP_ASSERT_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_TOP_ASSERT_SVH

// Clocked assertion, disabled while reset is low.
`define SFCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SFCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sfcs_pkg.sv */
package sfcs_pkg;

  localparam int unsigned ADDR_W       = 24;
  localparam int unsigned END_W        = ADDR_W + 1;
  localparam int unsigned STEP_W       = 6;
  localparam int unsigned POLL_W       = 16;
  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [POLL_W-1:0] POLL_LIMIT_RST = 16'd1000;
  localparam logic [STEP_W-1:0] ERASE_LOOP     = 6'd18;

  localparam logic [7:0] CMD_RDSR = 8'h05;
  localparam logic [7:0] CMD_WREN = 8'h06;
  localparam logic [7:0] CMD_EWSR = 8'h50;
  localparam logic [7:0] CMD_WRSR = 8'h01;
  localparam logic [7:0] CMD_PROG = 8'h02;
  localparam logic [7:0] CMD_READ = 8'h03;
  localparam logic [7:0] CMD_SE   = 8'h20;
  localparam logic [7:0] CMD_RDID = 8'h90;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    OP_RD_STATUS = 3'd0,
    OP_WR_STATUS = 3'd1,
    OP_RD_BYTE   = 3'd2,
    OP_PROG_BYTE = 3'd3,
    OP_ERASE     = 3'd4,
    OP_RD_ID     = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    K_IDLE = 4'd0,
    K_WAIT = 4'd1,
    K_STAT = 4'd2,
    K_WREN = 4'd3,
    K_EWSR = 4'd4,
    K_WRSR = 4'd5,
    K_WRS0 = 4'd6,
    K_READ = 4'd7,
    K_PROG = 4'd8,
    K_SE   = 4'd9,
    K_RDID = 4'd10,
    K_END  = 4'd11,
    K_NEXT = 4'd12
  } step_kind_e;

  typedef enum logic [1:0] {
    EV_SEND    = 2'd0,
    EV_RELEASE = 2'd1,
    EV_FINISH  = 2'd2
  } event_e;

  typedef struct packed {
    event_e     ev;
    logic [7:0] tx;
    logic [7:0] rv;
    logic [7:0] sv;
    logic       to;
  } res_t;

  // One or two results caused by one input item.
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } grp_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

  function automatic step_kind_e prog_kind(step_t step);
    step_kind_e k;
    case (step) inside
      6'd1:                                            k = K_STAT;
      6'd3, 6'd7, 6'd10, 6'd13, 6'd15, 6'd18,
      6'd20, 6'd23, 6'd24, 6'd27, 6'd29:               k = K_WAIT;
      6'd2, 6'd6, 6'd9, 6'd17, 6'd31:                  k = K_END;
      6'd4, 6'd11, 6'd21:                              k = K_EWSR;
      6'd5:                                            k = K_WRSR;
      6'd12, 6'd22:                                    k = K_WRS0;
      6'd14, 6'd19, 6'd25:                             k = K_WREN;
      6'd8:                                            k = K_READ;
      6'd16:                                           k = K_PROG;
      6'd26:                                           k = K_SE;
      6'd28:                                           k = K_NEXT;
      6'd30:                                           k = K_RDID;
      default:                                         k = K_IDLE;
    endcase
    return k;
  endfunction

  function automatic step_t op_start(logic [2:0] op);
    step_t s;
    unique case (op)
      OP_RD_STATUS: s = 6'd1;
      OP_WR_STATUS: s = 6'd3;
      OP_RD_BYTE:   s = 6'd7;
      OP_PROG_BYTE: s = 6'd10;
      OP_ERASE:     s = 6'd18;
      OP_RD_ID:     s = 6'd29;
      default:      s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] frame_len(step_kind_e k);
    logic [3:0] n;
    case (k) inside
      K_WREN, K_EWSR: n = 4'd1;
      K_READ, K_PROG: n = 4'd5;
      K_SE:           n = 4'd4;
      K_RDID:         n = 4'd6;
      default:        n = 4'd2;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] frame_byte(step_kind_e k, logic [2:0] i,
                                            logic [ADDR_W-1:0] addr, logic [7:0] data);
    logic [7:0] b;
    b = '0;
    if (i == 3'd0) begin
      case (k) inside
        K_WREN:         b = CMD_WREN;
        K_EWSR:         b = CMD_EWSR;
        K_WRSR, K_WRS0: b = CMD_WRSR;
        K_READ:         b = CMD_READ;
        K_PROG:         b = CMD_PROG;
        K_SE:           b = CMD_SE;
        K_RDID:         b = CMD_RDID;
        default:        b = CMD_RDSR;
      endcase
    end else if ((k == K_READ || k == K_PROG || k == K_SE) && i <= 3'd3) begin
      case (i)
        3'd1:    b = addr[23:16];
        3'd2:    b = addr[15:8];
        default: b = addr[7:0];
      endcase
    end else if ((k == K_PROG && i == 3'd4) || (k == K_WRSR && i == 3'd1)) begin
      b = data;
    end
    return b;
  endfunction

endpackage

/* rtl/sfcs_if.sv */
interface sfcs_req_if import sfcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [2:0]        operation;
  logic [ADDR_W-1:0] address;
  logic [END_W-1:0]  end_address;
  logic [7:0]        data_byte;
  logic [7:0]        rx_byte;

  modport source (output valid, kind, operation, address, end_address, data_byte, rx_byte,
                  input ready);
  modport sink   (input valid, kind, operation, address, end_address, data_byte, rx_byte,
                  output ready);
endinterface

interface sfcs_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] tx_byte;
  logic [7:0] read_value;
  logic [7:0] second_value;
  logic       timed_out;
  logic       last;

  modport source (output valid, event_res, tx_byte, read_value, second_value, timed_out, last,
                  input ready);
  modport sink   (input valid, event_res, tx_byte, read_value, second_value, timed_out, last,
                  output ready);
endinterface

interface sfcs_cfg_if import sfcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POLL_W-1:0] busy_poll_limit;

  modport source (output valid, busy_poll_limit, input ready);
  modport sink   (input valid, busy_poll_limit, output ready);
endinterface

/* rtl/sfcs_front.sv */
module sfcs_front import sfcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfcs_req_if.sink   req_i,
  sfcs_cfg_if.sink   cfg_i,
  input  q_status_t  q_status_i,
  output logic       push_o,
  output grp_t       grp_o
);

  step_t             step_q, step_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [END_W-1:0]  stop_q, stop_d;
  logic [7:0]        held_q, held_d;
  logic [POLL_W-1:0] poll_q, poll_d;
  logic [POLL_W-1:0] limit_q;
  logic [2:0]        fi_q, fi_d;
  logic [7:0]        cap0_q, cap0_d, cap1_q, cap1_d;

  step_kind_e        kind_cur, kind_nxt;
  logic [END_W-1:0]  nx;
  logic              accept, busy;
  step_t             step_inc;

  function automatic res_t send_res(logic [7:0] b);
    res_t r;
    r    = '0;
    r.ev = EV_SEND;
    r.tx = b;
    return r;
  endfunction

  function automatic res_t rel_res();
    res_t r;
    r    = '0;
    r.ev = EV_RELEASE;
    return r;
  endfunction

  function automatic res_t fin_res(logic [7:0] rv, logic [7:0] sv, logic to);
    res_t r;
    r    = '0;
    r.ev = EV_FINISH;
    r.rv = to ? 8'h00 : rv;
    r.sv = to ? 8'h00 : sv;
    r.to = to;
    return r;
  endfunction

  assign req_i.ready = !q_status_i.full;
  assign cfg_i.ready = 1'b1;
  assign accept      = req_i.valid && req_i.ready;
  assign step_inc    = step_q + 6'd1;
  assign kind_cur    = prog_kind(step_q);
  assign kind_nxt    = prog_kind(step_inc);
  assign nx          = {1'b0, addr_q} + END_W'(SECTOR_BYTES);

  always_comb begin
    step_d = step_q;
    addr_d = addr_q;
    stop_d = stop_q;
    held_d = held_q;
    poll_d = poll_q;
    fi_d   = fi_q;
    cap0_d = cap0_q;
    cap1_d = cap1_q;
    push_o = 1'b0;
    grp_o  = '0;
    busy   = 1'b0;
    if (accept) begin
      if (!req_i.kind) begin
        if (kind_cur == K_IDLE && req_i.operation <= OP_RD_ID) begin
          push_o = 1'b1;
          addr_d = req_i.address;
          stop_d = req_i.end_address;
          held_d = req_i.data_byte;
          cap0_d = '0;
          cap1_d = '0;
          poll_d = '0;
          fi_d   = '0;
          if (req_i.operation == OP_ERASE && {1'b0, req_i.address} >= req_i.end_address) begin
            step_d   = '0;
            grp_o.r0 = fin_res(8'h00, 8'h00, 1'b0);
          end else begin
            step_d   = op_start(req_i.operation);
            grp_o.r0 = send_res(frame_byte(prog_kind(op_start(req_i.operation)), 3'd0,
                                           req_i.address, req_i.data_byte));
          end
        end
      end else if (kind_cur != K_IDLE && kind_cur != K_END && kind_cur != K_NEXT) begin
        push_o = 1'b1;
        busy   = kind_cur == K_WAIT && fi_q == 3'd1 && req_i.rx_byte[0];
        if ((kind_cur == K_STAT && fi_q == 3'd1) ||
            ((kind_cur == K_READ || kind_cur == K_RDID) && fi_q == 3'd4)) begin
          cap0_d = req_i.rx_byte;
        end
        if (kind_cur == K_RDID && fi_q == 3'd5) begin
          cap1_d = req_i.rx_byte;
        end
        if (({1'b0, fi_q} + 4'd1) < frame_len(kind_cur)) begin
          fi_d     = fi_q + 3'd1;
          grp_o.r0 = send_res(frame_byte(kind_cur, fi_q + 3'd1, addr_q, held_q));
        end else begin
          grp_o.r0  = rel_res();
          grp_o.two = 1'b1;
          if (busy) begin
            if (poll_q >= limit_q) begin
              step_d   = '0;
              grp_o.r1 = fin_res(8'h00, 8'h00, 1'b1);
            end else begin
              poll_d   = poll_q + 16'd1;
              fi_d     = '0;
              grp_o.r1 = send_res(CMD_RDSR);
            end
          end else begin
            step_d = step_inc;
            unique case (kind_nxt)
              K_IDLE: begin
                grp_o.two = 1'b0;
              end
              K_END: begin
                step_d   = '0;
                grp_o.r1 = fin_res(cap0_d, cap1_d, 1'b0);
              end
              K_NEXT: begin
                if (nx < stop_q && !nx[END_W-1]) begin
                  addr_d   = nx[ADDR_W-1:0];
                  step_d   = ERASE_LOOP;
                  poll_d   = '0;
                  fi_d     = '0;
                  grp_o.r1 = send_res(frame_byte(prog_kind(ERASE_LOOP), 3'd0,
                                                 nx[ADDR_W-1:0], held_q));
                end else begin
                  step_d   = '0;
                  grp_o.r1 = fin_res(cap0_d, cap1_d, 1'b0);
                end
              end
              default: begin
                if (kind_nxt == K_WAIT) begin
                  poll_d = '0;
                end
                fi_d     = '0;
                grp_o.r1 = send_res(frame_byte(kind_nxt, 3'd0, addr_q, held_q));
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      addr_q  <= '0;
      stop_q  <= '0;
      held_q  <= '0;
      poll_q  <= '0;
      fi_q    <= '0;
      cap0_q  <= '0;
      cap1_q  <= '0;
      limit_q <= POLL_LIMIT_RST;
    end else begin
      step_q <= step_d;
      addr_q <= addr_d;
      stop_q <= stop_d;
      held_q <= held_d;
      poll_q <= poll_d;
      fi_q   <= fi_d;
      cap0_q <= cap0_d;
      cap1_q <= cap1_d;
      if (cfg_i.valid && cfg_i.ready) begin
        limit_q <= cfg_i.busy_poll_limit;
      end
    end
  end

endmodule

/* rtl/sfcs_queue.sv */
module sfcs_queue import sfcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  grp_t      grp_i,
  input  logic      pop_i,
  output grp_t      head_o,
  output q_status_t status_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  grp_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return n;
  endfunction

  assign status_o.full     = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign status_o.nonempty = cnt_q != '0;
  assign head_o            = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= grp_i;
    end
  end

endmodule

/* rtl/sfcs_back.sv */
module sfcs_back import sfcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  grp_t       head_i,
  input  q_status_t  q_status_i,
  output logic       pop_o,
  sfcs_res_if.source res_o
);

  logic idx_q, idx_d;
  logic fire, is_last;
  res_t sel;

  assign sel     = idx_q ? head_i.r1 : head_i.r0;
  assign is_last = idx_q || !head_i.two;
  assign fire    = res_o.valid && res_o.ready;
  assign pop_o   = fire && is_last;

  assign res_o.valid        = q_status_i.nonempty;
  assign res_o.event_res    = sel.ev;
  assign res_o.tx_byte      = sel.tx;
  assign res_o.read_value   = sel.rv;
  assign res_o.second_value = sel.sv;
  assign res_o.timed_out    = sel.to;
  assign res_o.last         = is_last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = !is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

/* rtl/spi_flash_command_sequencer_top.sv */
// SPI NOR flash command sequencer.
// req_i takes either a new request (kind 0) or the byte returned by the
// last SPI transfer (kind 1); each returned byte advances the sequence by
// one step. res_o gives, per input, zero to two results: send a byte with
// select low, release select, or operation finished; last marks the final
// result of an input. cfg_i writes busy_poll_limit at any transfer.
// Results of an input are registered in the queue and reach res_o from
// there. Throughput: one input per cycle while req_i is ready; results
// leave at one per cycle while the receiver is ready. The rate
// is set by the single result port draining a two-entry queue of result
// groups that sits between the sequencer and the output.
// Reset: the sequencer is idle, busy_poll_limit is 1000, the queue is empty.
// When the receiver stalls, results wait in the queue; once it holds two
// groups req_i drops ready until a group has left.
module spi_flash_command_sequencer_top import sfcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfcs_req_if.sink   req_i,
  sfcs_cfg_if.sink   cfg_i,
  sfcs_res_if.source res_o
);

  logic      push, pop;
  grp_t      grp, head;
  q_status_t q_status;

  sfcs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_i      (cfg_i),
    .q_status_i (q_status),
    .push_o     (push),
    .grp_o      (grp)
  );

  sfcs_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .grp_i    (grp),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  sfcs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .res_o      (res_o)
  );

endmodule

/* rtl/sfcs_checker.sv */
`include "spi_flash_command_sequencer_top_assert.svh"

module sfcs_checker import sfcs_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [1:0] event_res_i,
  input logic [7:0] read_value_i,
  input logic [7:0] second_value_i,
  input logic       timed_out_i,
  input logic       last_i
);

  `SFCS_ASSERT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i |=> res_valid_i, "result dropped while stalled")
  `SFCS_ASSERT(a_group_cont, clk_i, rst_ni, res_valid_i && res_ready_i && !last_i |=> res_valid_i, "result group cut short")
  `SFCS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !res_valid_i, "result during reset")
  `SFCS_ASSERT_ALWAYS(a_timeout_fin, clk_i, res_valid_i && timed_out_i |-> event_res_i == EV_FINISH && last_i && read_value_i == 8'h00 && second_value_i == 8'h00, "bad timeout result")

endmodule

bind spi_flash_command_sequencer_top sfcs_checker u_sfcs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .event_res_i    (res_o.event_res),
  .read_value_i   (res_o.read_value),
  .second_value_i (res_o.second_value),
  .timed_out_i    (res_o.timed_out),
  .last_i         (res_o.last)
);

/* bench/spi_flash_command_sequencer_top_test.sv */
module spi_flash_command_sequencer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sfcs_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int OP_GUARD      = 6000;
  localparam int RANDOM_ITEMS  = 50;
  localparam int IDLE_PCT      = 19;
  localparam int STALL_CYCLES  = 400;

  typedef struct packed {
    logic              kind;
    logic [2:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [END_W-1:0]  end_address;
    logic [7:0]        data_byte;
    logic [7:0]        rx_byte;
  } flash_input_t;

  typedef struct packed {
    event_e     ev;
    logic [7:0] tx;
    logic [7:0] rv;
    logic [7:0] sv;
    logic       to;
    logic       last;
  } spi_event_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sfcs_req_if req_if ();
  sfcs_cfg_if cfg_if ();
  sfcs_res_if res_if ();

  spi_flash_command_sequencer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // sequencer mirror
  step_t             phase_step;
  logic [ADDR_W-1:0] walk_addr;
  logic [END_W-1:0]  range_end;
  logic [7:0]        wr_data;
  logic [POLL_W-1:0] polls;
  logic [2:0]        byte_pos;
  logic [7:0]        id_bytes [2];
  logic [POLL_W-1:0] poll_limit;

  spi_event_t step_out [$];
  spi_event_t pending_events [$];

  int mismatches     = 0;
  int results_seen   = 0;
  int useful_items   = 0;
  int ops_finished   = 0;
  int ops_timed_out  = 0;
  int transfers_sent = 0;
  int unsigned cycle_count = 0;

  bit tx_steady  = 1'b0;
  bit rx_steady  = 1'b0;
  int stall_left = 0;

  function automatic step_kind_e kind_at(step_t s);
    step_kind_e k;
    case (s)
      6'd1:                                           k = K_STAT;
      6'd2, 6'd6, 6'd9, 6'd17, 6'd31:                 k = K_END;
      6'd3, 6'd7, 6'd10, 6'd13, 6'd15, 6'd18, 6'd20,
      6'd23, 6'd24, 6'd27, 6'd29:                     k = K_WAIT;
      6'd4, 6'd11, 6'd21:                             k = K_EWSR;
      6'd5:                                           k = K_WRSR;
      6'd12, 6'd22:                                   k = K_WRS0;
      6'd14, 6'd19, 6'd25:                            k = K_WREN;
      6'd8:                                           k = K_READ;
      6'd16:                                          k = K_PROG;
      6'd26:                                          k = K_SE;
      6'd28:                                          k = K_NEXT;
      6'd30:                                          k = K_RDID;
      default:                                        k = K_IDLE;
    endcase
    return k;
  endfunction

  function automatic step_t entry_step(logic [2:0] op);
    step_t s;
    case (op)
      OP_RD_STATUS: s = 6'd1;
      OP_WR_STATUS: s = 6'd3;
      OP_RD_BYTE:   s = 6'd7;
      OP_PROG_BYTE: s = 6'd10;
      OP_ERASE:     s = ERASE_LOOP;
      default:      s = 6'd29;
    endcase
    return s;
  endfunction

  function automatic int bytes_in_frame(step_kind_e k);
    int n;
    case (k)
      K_WREN, K_EWSR: n = 1;
      K_READ, K_PROG: n = 5;
      K_SE:           n = 4;
      K_RDID:         n = 6;
      default:        n = 2;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] frame_out(step_kind_e k, int i);
    logic [ADDR_W-1:0] shifted;
    logic [7:0] b;
    b = 8'h00;
    if (i == 0) begin
      case (k)
        K_WREN:         b = CMD_WREN;
        K_EWSR:         b = CMD_EWSR;
        K_WRSR, K_WRS0: b = CMD_WRSR;
        K_READ:         b = CMD_READ;
        K_PROG:         b = CMD_PROG;
        K_SE:           b = CMD_SE;
        K_RDID:         b = CMD_RDID;
        default:        b = CMD_RDSR;
      endcase
    end else if ((k == K_READ || k == K_PROG || k == K_SE) && i <= 3) begin
      shifted = walk_addr >> (8 * (3 - i));
      b = shifted[7:0];
    end else if ((k == K_PROG && i == 4) || (k == K_WRSR && i == 1)) begin
      b = wr_data;
    end
    return b;
  endfunction

  function automatic void add_event(event_e ev, logic [7:0] tx, logic [7:0] rv,
                                    logic [7:0] sv, logic to);
    spi_event_t e;
    e.ev = ev;
    e.tx = tx;
    e.rv = rv;
    e.sv = sv;
    e.to = to;
    e.last = 1'b0;
    step_out.push_back(e);
  endfunction

  function automatic void close_op(logic to);
    if (to)
      add_event(EV_FINISH, 8'h00, 8'h00, 8'h00, 1'b1);
    else
      add_event(EV_FINISH, 8'h00, id_bytes[0], id_bytes[1], 1'b0);
    phase_step = '0;
    ops_finished++;
    if (to)
      ops_timed_out++;
  endfunction

  // Runs through end and next-sector steps until a frame opens or the op closes.
  function automatic void open_frame();
    step_kind_e k;
    logic [END_W-1:0] nxt;
    while (1'b1) begin
      k = kind_at(phase_step);
      if (k == K_IDLE)
        return;
      if (k == K_END) begin
        close_op(1'b0);
        return;
      end
      if (k == K_NEXT) begin
        nxt = {1'b0, walk_addr} + END_W'(SECTOR_BYTES);
        if (nxt < range_end && !nxt[ADDR_W]) begin
          walk_addr = nxt[ADDR_W-1:0];
          phase_step = ERASE_LOOP;
        end else begin
          close_op(1'b0);
          return;
        end
      end else begin
        if (k == K_WAIT)
          polls = '0;
        byte_pos = '0;
        add_event(EV_SEND, frame_out(k, 0), 8'h00, 8'h00, 1'b0);
        return;
      end
    end
  endfunction

  function automatic void reset_sequencer_mirror();
    phase_step = '0;
    walk_addr = '0;
    range_end = '0;
    wr_data = '0;
    polls = '0;
    byte_pos = '0;
    id_bytes[0] = '0;
    id_bytes[1] = '0;
    poll_limit = POLL_LIMIT_RST;
  endfunction

  // Updates the mirror for one accepted transfer and queues what it causes.
  function automatic void predict_transfer(flash_input_t it);
    step_kind_e k;
    int i;
    bit busy;
    spi_event_t e;
    k = kind_at(phase_step);
    step_out.delete();
    if (!it.kind) begin
      if (k != K_IDLE || it.operation > OP_RD_ID)
        return;
      walk_addr = it.address;
      range_end = it.end_address;
      wr_data = it.data_byte;
      id_bytes[0] = '0;
      id_bytes[1] = '0;
      polls = '0;
      byte_pos = '0;
      if (it.operation == OP_ERASE && {1'b0, walk_addr} >= range_end) begin
        close_op(1'b0);
      end else begin
        phase_step = entry_step(it.operation);
        open_frame();
      end
    end else begin
      if (k == K_IDLE || k == K_END || k == K_NEXT)
        return;
      i = int'(byte_pos);
      busy = (k == K_WAIT && i == 1) && it.rx_byte[0];
      if ((k == K_STAT && i == 1) || ((k == K_READ || k == K_RDID) && i == 4))
        id_bytes[0] = it.rx_byte;
      if (k == K_RDID && i == 5)
        id_bytes[1] = it.rx_byte;
      if (i + 1 < bytes_in_frame(k)) begin
        byte_pos = 3'(i + 1);
        add_event(EV_SEND, frame_out(k, i + 1), 8'h00, 8'h00, 1'b0);
      end else begin
        add_event(EV_RELEASE, 8'h00, 8'h00, 8'h00, 1'b0);
        if (k == K_WAIT && busy) begin
          if (polls >= poll_limit) begin
            close_op(1'b1);
          end else begin
            polls = polls + 1'b1;
            byte_pos = '0;
            add_event(EV_SEND, CMD_RDSR, 8'h00, 8'h00, 1'b0);
          end
        end else begin
          phase_step = phase_step + 1'b1;
          open_frame();
        end
      end
    end
    useful_items++;
    foreach (step_out[j]) begin
      e = step_out[j];
      e.last = (j == step_out.size() - 1);
      pending_events.push_back(e);
    end
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    spi_event_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (pending_events.size() == 0) begin
        $error("result with nothing outstanding: event_res %0d tx_byte %0h",
               res_if.event_res, res_if.tx_byte);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        compare_field("event_res", {6'b0, want.ev}, {6'b0, res_if.event_res});
        compare_field("tx_byte", want.tx, res_if.tx_byte);
        compare_field("read_value", want.rv, res_if.read_value);
        compare_field("second_value", want.sv, res_if.second_value);
        compare_field("timed_out", {7'b0, want.to}, {7'b0, res_if.timed_out});
        compare_field("last", {7'b0, want.last}, {7'b0, res_if.last});
      end
    end
  end

  // result side: random back-pressure, plus a counted hold-off on request
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      res_if.ready = 1'b0;
      stall_left--;
    end else begin
      res_if.ready = rx_steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Every task below starts and ends at a falling edge.
  task automatic send_item(input flash_input_t it);
    if (!tx_steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.kind = it.kind;
    req_if.operation = it.operation;
    req_if.address = it.address;
    req_if.end_address = it.end_address;
    req_if.data_byte = it.data_byte;
    req_if.rx_byte = it.rx_byte;
    do @(posedge clk_i); while (!req_if.ready);
    predict_transfer(it);
    transfers_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    int waited;
    req_if.valid = 1'b0;
    waited = 0;
    while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_poll_limit(input logic [POLL_W-1:0] lim);
    drain_results();
    cfg_if.valid = 1'b1;
    cfg_if.busy_poll_limit = lim;
    do @(posedge clk_i); while (!cfg_if.ready);
    poll_limit = lim;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  function automatic flash_input_t random_fields();
    flash_input_t it;
    it.kind = 1'b0;
    it.operation = 3'($urandom_range(0, 7));
    it.address = ADDR_W'($urandom());
    it.end_address = END_W'($urandom());
    it.data_byte = 8'($urandom());
    it.rx_byte = 8'($urandom());
    return it;
  endfunction

  // Returned byte; the busy bit is biased only where it is the status byte of a busy wait.
  task automatic send_returned_byte(input int busy_pct);
    flash_input_t it;
    it = random_fields();
    it.kind = 1'b1;
    if (kind_at(phase_step) == K_WAIT && byte_pos == 3'd1)
      it.rx_byte[0] = ($urandom_range(0, 99) < busy_pct);
    send_item(it);
  endtask

  task automatic send_idle_noise();
    flash_input_t it;
    it = random_fields();
    if ($urandom_range(0, 1))
      it.kind = 1'b1;
    else
      it.operation = 3'($urandom_range(6, 7));
    send_item(it);
  endtask

  task automatic run_operation(input logic [2:0] op, input logic [ADDR_W-1:0] addr,
                               input logic [END_W-1:0] stop, input logic [7:0] data,
                               input int busy_pct, input int noise_pct);
    flash_input_t it;
    int guard;
    it = random_fields();
    it.operation = op;
    it.address = addr;
    it.end_address = stop;
    it.data_byte = data;
    send_item(it);
    guard = 0;
    while (kind_at(phase_step) != K_IDLE && guard < OP_GUARD) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(random_fields());
      else
        send_returned_byte(busy_pct);
      guard++;
    end
  endtask

  function automatic int pick_busy(bit allow_stuck);
    int b;
    case ($urandom_range(0, allow_stuck ? 3 : 2))
      0:       b = 0;
      1:       b = 25;
      2:       b = 50;
      default: b = 90;
    endcase
    return b;
  endfunction

  task automatic random_operation(input int busy_pct, input int noise_pct);
    logic [2:0] op;
    logic [ADDR_W-1:0] start;
    logic [END_W-1:0] stop;
    op = 3'($urandom_range(0, 5));
    start = ADDR_W'($urandom());
    stop = END_W'($urandom());
    if (op == OP_ERASE) begin
      case ($urandom_range(0, 9))
        0: stop = END_W'($urandom_range(0, int'(start)));
        1, 2: begin
          start = 24'hFFFFFF - ADDR_W'($urandom_range(0, 3 * SECTOR_BYTES));
          if ($urandom_range(0, 1))
            stop = 25'h1000000;
          else
            stop = END_W'($urandom_range(32'h1000000, 32'h1FFFFFF));
        end
        default: stop = {1'b0, start} + END_W'($urandom_range(1, 3 * SECTOR_BYTES));
      endcase
    end
    if ($urandom_range(0, 99) < noise_pct)
      send_idle_noise();
    run_operation(op, start, stop, 8'($urandom()), busy_pct, noise_pct);
  endtask

  // Reset value of the limit: long runs of busy polls pass without a timeout.
  task automatic test_reset_poll_limit();
    run_operation(OP_RD_STATUS, '0, '0, 8'h00, 0, 0);
    run_operation(OP_WR_STATUS, '0, '0, 8'h5A, 80, 0);
    run_operation(OP_RD_BYTE, 24'h00A5A5, '0, 8'h00, 80, 0);
  endtask

  task automatic test_each_operation();
    set_poll_limit(16'd3);
    run_operation(OP_RD_STATUS, 24'h000000, 25'h0000000, 8'h00, 40, 0);
    run_operation(OP_WR_STATUS, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF, 40, 0);
    run_operation(OP_WR_STATUS, 24'h000000, 25'h0000000, 8'h00, 40, 0);
    run_operation(OP_RD_BYTE, 24'hFFFFFF, 25'h0000000, 8'h00, 40, 0);
    run_operation(OP_RD_BYTE, 24'h000000, 25'h1FFFFFF, 8'hFF, 40, 0);
    run_operation(OP_PROG_BYTE, 24'hA55A3C, 25'h0000000, 8'h00, 40, 0);
    run_operation(OP_PROG_BYTE, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF, 40, 0);
    run_operation(OP_ERASE, 24'h000000, 25'h0001000, 8'h00, 40, 0);
    run_operation(OP_RD_ID, 24'h123456, 25'h0000000, 8'h00, 40, 0);
  endtask

  task automatic test_erase_ranges();
    run_operation(OP_ERASE, 24'h005000, 25'h0005000, 8'h00, 30, 0);
    run_operation(OP_ERASE, 24'hFFFFFF, 25'h0000000, 8'h00, 30, 0);
    run_operation(OP_ERASE, 24'h0007FF, 25'h0001800, 8'h00, 30, 0);
    run_operation(OP_ERASE, 24'hFFE000, 25'h1000000, 8'h00, 30, 0);
    run_operation(OP_ERASE, 24'hFFF800, 25'h1FFFFFF, 8'h00, 30, 0);
  endtask

  task automatic test_ignored_items();
    flash_input_t it;
    it = random_fields();
    it.kind = 1'b1;
    send_item(it);
    it = random_fields();
    it.operation = 3'd6;
    send_item(it);
    it.operation = 3'd7;
    send_item(it);
    run_operation(OP_RD_ID, 24'h000000, 25'h0000000, 8'h00, 40, 30);
    run_operation(OP_PROG_BYTE, 24'h00FF00, 25'h0000000, 8'hC3, 40, 30);
  endtask

  task automatic test_busy_timeouts();
    set_poll_limit(16'd0);
    run_operation(OP_RD_BYTE, 24'h0F0F0F, 25'h0000000, 8'h00, 100, 0);
    run_operation(OP_RD_STATUS, 24'h000000, 25'h0000000, 8'h00, 100, 0);
    set_poll_limit(16'd1);
    run_operation(OP_PROG_BYTE, 24'h3C3C3C, 25'h0000000, 8'h81, 100, 0);
    run_operation(OP_ERASE, 24'h010000, 25'h0012000, 8'h00, 60, 0);
    set_poll_limit(16'hFFFF);
    run_operation(OP_ERASE, 24'h020000, 25'h0022000, 8'h00, 50, 0);
    run_operation(OP_RD_ID, 24'h000000, 25'h0000000, 8'h00, 50, 0);
  endtask

  task automatic test_random_traffic();
    int first;
    first = useful_items;
    while (useful_items - first < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0:       set_poll_limit(16'hFFFF);
          1:       set_poll_limit(16'd0);
          2:       set_poll_limit(POLL_W'($urandom_range(1, 65535)));
          default: set_poll_limit(POLL_W'($urandom_range(1, 6)));
        endcase
      end
      random_operation(pick_busy(poll_limit <= 16'd6), 8);
    end
  endtask

  // Result side held off while requests keep coming, so the block backs up.
  task automatic test_output_stall();
    drain_results();
    stall_left = STALL_CYCLES;
    repeat (4) random_operation(30, 0);
  endtask

  task automatic test_full_rate();
    drain_results();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (8) random_operation(pick_busy(1'b0), 0);
    drain_results();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.kind = 1'b0;
    req_if.operation = '0;
    req_if.address = '0;
    req_if.end_address = '0;
    req_if.data_byte = '0;
    req_if.rx_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.busy_poll_limit = '0;
    res_if.ready = 1'b0;
    reset_sequencer_mirror();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_poll_limit();
    test_each_operation();
    test_erase_ranges();
    test_ignored_items();
    test_busy_timeouts();
    test_output_stall();
    test_full_rate();
    test_random_traffic();

    drain_results();
    if (pending_events.size() != 0) begin
      $error("%0d expected results never arrived", pending_events.size());
      mismatches++;
    end
    $display("Covered %0d flash operations (%0d abandoned on busy timeout) over %0d transfers,",
             ops_finished, ops_timed_out, transfers_sent);
    $display("with %0d of them acted on and %0d results compared.", useful_items, results_seen);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
